@@ rtl/core/tocs_pkg.sv @@
// ----------------------------------------------------------------------------
// Trajectory obstacle cost scorer package
// Shared types and constants for the scorer's accumulator, multiplier
// and sequencer.
// ----------------------------------------------------------------------------
package tocs_pkg;

    // Costmap codes
    localparam logic [7:0] COST_FREE      = 8'd0;
    localparam logic [7:0] COST_INSCRIBED = 8'd253;
    localparam logic [7:0] COST_LETHAL    = 8'd254;
    localparam logic [7:0] COST_UNKNOWN   = 8'd255;

    // Width of the raw cost handed to the scaling step, and of the result
    localparam int RAW_W = 48;
    localparam int HALF_W = 24;
    localparam int OPR_W = 32;
    localparam int PROD_W = 64;
    localparam logic [RAW_W-1:0] COST_MAX = {RAW_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_COST  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLLISION_COST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_FOOTPRINT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_UNKNOWN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COST_POWER     = 3'd5;

    typedef struct packed {
        logic [31:0] scale_factor;
        logic [15:0] critical_cost;
        logic [23:0] collision_cost;
        logic        use_footprint;
        logic        track_unknown;
        logic [1:0]  cost_power;
    } tocs_cfg_t;

    localparam tocs_cfg_t CFG_RESET = '{
        scale_factor:   32'd64424509,
        critical_cost:  16'd300,
        collision_cost: 24'd1000000,
        use_footprint:  1'b1,
        track_unknown:  1'b0,
        cost_power:     2'd1
    };

    // One trajectory point
    typedef struct packed {
        logic [7:0] cell_cost;
        logic       in_goal_zone;
        logic       last_point;
        logic       last_trajectory;
    } tocs_in_t;

    // One trajectory result
    typedef struct packed {
        logic [47:0] trajectory_cost;
        logic        collided;
        logic        all_collide;
        logic        batch_done;
    } tocs_out_t;

    // End-of-trajectory summary from the accumulator to the sequencer
    typedef struct packed {
        logic [RAW_W-1:0] raw;
        logic             collided;
        logic             all_collide;
        logic             batch_done;
    } tocs_end_t;

    // Sequencer states
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL_LO = 7'b0000010,
        S_MUL_HI = 7'b0000100,
        S_SCALE  = 7'b0001000,
        S_SQUARE = 7'b0010000,
        S_ROUND  = 7'b0100000,
        S_DONE   = 7'b1000000
    } tocs_state_t;

endpackage

@@ rtl/core/tocs_accum.sv @@
// ----------------------------------------------------------------------------
// Trajectory point accumulator
// Classifies each point's cell cost, keeps the saturating cost sum, the
// collision flag and the batch-wide free-trajectory flag.
// ----------------------------------------------------------------------------
module tocs_accum
    import tocs_pkg::*;
#(
    parameter int SUM_WIDTH = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      point_take,
    input  tocs_in_t  point,
    input  tocs_cfg_t cfg,
    output tocs_end_t end_info
);

    localparam int EXT_W = SUM_WIDTH + 1;

    logic [SUM_WIDTH-1:0] sum_reg, sum_next;
    logic                 hit_reg, hit_next;
    logic                 some_free_reg, some_free_next;

    logic                 active;
    logic                 coll;
    logic [15:0]          add;
    logic [EXT_W-1:0]     sum_ext;
    logic [SUM_WIDTH-1:0] sum_sat;
    logic                 hit_now;
    logic [SUM_WIDTH-1:0] sum_now;

    // Classify the cell and work out what it adds.
    always_comb begin
        active = !hit_reg && (point.cell_cost != COST_FREE);
        coll = (point.cell_cost == COST_LETHAL) ||
               ((point.cell_cost == COST_INSCRIBED) && !cfg.use_footprint) ||
               ((point.cell_cost == COST_UNKNOWN) && !cfg.track_unknown);
        if (point.cell_cost >= COST_INSCRIBED) begin
            add = cfg.critical_cost;
        end else if (point.in_goal_zone) begin
            add = 16'd0;
        end else begin
            add = {8'd0, point.cell_cost};
        end
        sum_ext = {1'b0, sum_reg} + EXT_W'(add);
        sum_sat = sum_ext[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_ext[SUM_WIDTH-1:0];
        hit_now = hit_reg || (active && coll);
        sum_now = (active && !coll) ? sum_sat : sum_reg;
    end

    // Summary of the trajectory, valid on its last point.
    always_comb begin
        end_info.raw = hit_now ? RAW_W'(cfg.collision_cost) : RAW_W'(sum_now);
        end_info.collided = hit_now;
        end_info.all_collide = point.last_trajectory && !(some_free_reg || !hit_now);
        end_info.batch_done = point.last_trajectory;
    end

    // State update: the last point clears the trajectory state.
    always_comb begin
        sum_next = sum_reg;
        hit_next = hit_reg;
        some_free_next = some_free_reg;
        if (point_take) begin
            if (point.last_point) begin
                sum_next = '0;
                hit_next = 1'b0;
                some_free_next = point.last_trajectory ? 1'b0 :
                                 (some_free_reg || !hit_now);
            end else begin
                sum_next = sum_now;
                hit_next = hit_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            hit_reg <= 1'b0;
            some_free_reg <= 1'b0;
        end else begin
            sum_reg <= sum_next;
            hit_reg <= hit_next;
            some_free_reg <= some_free_next;
        end
    end

endmodule

@@ rtl/core/tocs_mul.sv @@
// ----------------------------------------------------------------------------
// Shared multiplier
// A 32 by 32 bit unsigned multiplier with a registered product, used in
// turn for both scaling halves and for squaring.
// ----------------------------------------------------------------------------
module tocs_mul
    import tocs_pkg::*;
(
    input  logic              aclk,
    input  logic              mul_load,
    input  logic [OPR_W-1:0]  mul_a,
    input  logic [OPR_W-1:0]  mul_b,
    output logic [PROD_W-1:0] mul_prod
);

    logic [PROD_W-1:0] prod_reg;

    // Product register holds until the next load.
    always_ff @(posedge aclk) begin
        if (mul_load) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    assign mul_prod = prod_reg;

endmodule

@@ rtl/core/trajectory_obstacle_cost_scorer.sv @@
// ----------------------------------------------------------------------------
// Trajectory obstacle cost scorer
// Points of candidate trajectories enter on s_*, one result per trajectory
// leaves on m_*, registers are written on cfg_*.
//
// Each input transaction carries one point's costmap cell cost. A point that
// is not the last of its trajectory is absorbed and s_ready stays high. The
// last point starts the scaling sequence on the shared 32x32 multiplier:
// low half, high half, combine, and two more steps when cost_power selects
// squaring. s_ready stays low from that transaction until the result is
// loaded into the output register and presented on m_valid. The multiplier
// is used up to three times per trajectory.
// The result sits in an output register: if the receiver stalls, the next
// trajectory's points are still taken, and only its result waits in the
// final step until the earlier result has been taken.
// Reset (aresetn, synchronous, active low) clears the sum and flags, empties
// the output register and loads the register defaults. cfg_ready is always
// high; registers are to be written while the block is idle.
// ----------------------------------------------------------------------------
module trajectory_obstacle_cost_scorer
    import tocs_pkg::*;
#(
    parameter int SUM_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tocs_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tocs_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tocs_cfg_t   cfg_reg;
    tocs_state_t state_reg, state_next;
    tocs_end_t   end_info;
    tocs_end_t   end_reg;
    logic [39:0]      lo_reg;
    logic [RAW_W-1:0] val_reg;
    logic             m_valid_reg;
    tocs_out_t        m_data_reg;

    logic              point_take;
    logic              mul_load;
    logic [OPR_W-1:0]  mul_a;
    logic [OPR_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_prod;
    logic [RAW_W:0]    comb_sum;
    logic [RAW_W-1:0]  scaled;
    logic              out_free;

    assign s_ready = (state_reg == S_IDLE);
    assign point_take = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free = !m_valid_reg || m_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SCALE_FACTOR:   cfg_reg.scale_factor <= cfg_data;
                CFG_CRITICAL_COST:  cfg_reg.critical_cost <= cfg_data[15:0];
                CFG_COLLISION_COST: cfg_reg.collision_cost <= cfg_data[23:0];
                CFG_USE_FOOTPRINT:  cfg_reg.use_footprint <= cfg_data[0];
                CFG_TRACK_UNKNOWN:  cfg_reg.track_unknown <= cfg_data[0];
                CFG_COST_POWER:     cfg_reg.cost_power <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Per-point accumulation
    tocs_accum #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .point_take (point_take),
        .point      (s_data),
        .cfg        (cfg_reg),
        .end_info   (end_info)
    );

    // Operand selection for the shared multiplier
    always_comb begin
        mul_load = 1'b0;
        mul_a = '0;
        mul_b = cfg_reg.scale_factor;
        unique case (state_reg)
            S_MUL_LO: begin
                mul_load = 1'b1;
                mul_a = OPR_W'(end_reg.raw[HALF_W-1:0]);
            end
            S_MUL_HI: begin
                mul_load = 1'b1;
                mul_a = OPR_W'(end_reg.raw[RAW_W-1:HALF_W]);
            end
            S_SQUARE: begin
                mul_load = 1'b1;
                mul_a = val_reg[OPR_W-1:0];
                mul_b = val_reg[OPR_W-1:0];
            end
            default: ;
        endcase
    end

    tocs_mul u_mul (
        .aclk     (aclk),
        .mul_load (mul_load),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_prod (mul_prod)
    );

    // Combine the two scaling halves: (high << 8) + (low >> 16), saturated.
    always_comb begin
        comb_sum = {1'b0, mul_prod[39:0], 8'h00} + (RAW_W + 1)'(lo_reg);
        if ((|mul_prod[PROD_W-1:40]) || comb_sum[RAW_W]) begin
            scaled = COST_MAX;
        end else begin
            scaled = comb_sum[RAW_W-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (point_take && s_data.last_point) begin
                    state_next = S_MUL_LO;
                end
            end
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_SCALE;
            S_SCALE:  state_next = cfg_reg.cost_power[1] ? S_SQUARE : S_DONE;
            S_SQUARE: state_next = S_ROUND;
            S_ROUND:  state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers of the sequence
    always_ff @(posedge aclk) begin
        if (point_take && s_data.last_point) begin
            end_reg <= end_info;
        end
        if (state_reg == S_MUL_HI) begin
            lo_reg <= mul_prod[55:16];
        end
        if (state_reg == S_SCALE) begin
            val_reg <= scaled;
        end
        if (state_reg == S_ROUND) begin
            val_reg <= (|val_reg[RAW_W-1:OPR_W]) ? COST_MAX : mul_prod[PROD_W-1:16];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_data_reg.trajectory_cost <= val_reg;
            m_data_reg.collided <= end_reg.collided;
            m_data_reg.all_collide <= end_reg.all_collide;
            m_data_reg.batch_done <= end_reg.batch_done;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule
